[rtl/tcw_pkg.sv]
// Shared constants of the text console writer.
// Holds command codes, control characters and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Stream field widths
    localparam int CMD_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int OCOL_W    = 7;
    localparam int OROW_W    = 5;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

    // Attribute after reset: white on black
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

endpackage

`default_nettype wire

[rtl/tcw_screen_ram.sv]
// Screen cell memory: one write port, one read port with registered data.
// Depends on tcw_pkg for the cell width.
`timescale 1ns / 1ps
`default_nettype none

module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  wire                        aclk,
    input  wire                        we,
    input  wire  [ADDR_W-1:0]          waddr,
    input  wire  [tcw_pkg::CELL_W-1:0] wdata,
    input  wire                        re,
    input  wire  [ADDR_W-1:0]          raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/text_console_writer_top.sv]
// Text console writer top level: cursor sequencer and screen memory sweeps.
// Depends on tcw_pkg and tcw_screen_ram.
// One word at a time; the row move and clear are a sweep of one cell per cycle
// through the single write port of the screen memory.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the screen
// while s_axis_tready stays low.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    // Attribute register write
    input  wire                          cfg_wr_en,
    input  wire  [tcw_pkg::ATTR_W-1:0]   cfg_wr_data,
    // Command stream
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  wire  [tcw_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [1:0] command
    input  wire  [tcw_pkg::CMD_W-1:0]    s_axis_tuser,
    // Result stream
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // [6:0] cursor_col, [11:7] cursor_row, [19:12] read_char,
    // [27:20] read_attr, [28] scrolled, [31:29] zero
    output logic [tcw_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import tcw_pkg::*;

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int MOVE_N    = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS + 1);
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int PH_W      = $clog2(TAB_STOP);
    localparam int PH_SAT    = COLUMNS % TAB_STOP;
    localparam int IDX_CMP_W = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 1;
    localparam int PAD_W     = M_DATA_W - (OCOL_W + OROW_W + 2 * CHAR_W + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_SWEEP_END,
        S_PUT,
        S_RDWAIT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_CLEAR,
        SW_SCROLL
    } sweep_t;

    state_t              state_reg, state_next;
    sweep_t              sw_mode_reg, sw_mode_next;
    logic [ADDR_W-1:0]   sw_ptr_reg, sw_ptr_next;
    logic                wpend_reg, wpend_next;
    logic [ADDR_W-1:0]   waddr_reg, waddr_next;
    logic                wsrc_reg, wsrc_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [PH_W-1:0]     phase_reg, phase_next;
    logic [ATTR_W-1:0]   attr_reg, attr_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                rd_hit_reg, rd_hit_next;
    logic [CHAR_W-1:0]   res_char_reg, res_char_next;
    logic [ATTR_W-1:0]   res_attr_reg, res_attr_next;
    logic                res_scr_reg, res_scr_next;
    logic                out_valid_reg, out_valid_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    // Input fields
    logic [CMD_W-1:0]    in_cmd;
    logic [CHAR_W-1:0]   in_char;
    logic [IDX_W-1:0]    in_idx;
    logic                in_take;
    logic                idx_ok;

    // Cursor arithmetic
    logic                wrap_pend;
    logic                is_ctrl;
    logic [ROW_W-1:0]    row_inc;
    logic [ROW_W-1:0]    row_wrap;
    logic [COL_W:0]      tab_tgt;
    logic [PH_W-1:0]     phase_inc;
    logic [ADDR_W-1:0]   put_addr;
    logic                sw_move;

    // Memory ports
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    assign in_cmd  = s_axis_tuser;
    assign in_char = s_axis_tdata[CHAR_W-1:0];
    assign in_idx  = s_axis_tdata[CHAR_W+IDX_W-1:CHAR_W];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign idx_ok        = IDX_CMP_W'(in_idx) < IDX_CMP_W'(CELLS);

    assign wrap_pend = (col_reg >= COL_W'(COLUMNS));
    assign is_ctrl   = (in_char == CH_LF) || (in_char == CH_CR) ||
                       (in_char == CH_BS) || (in_char == CH_TAB);
    assign row_inc   = (row_reg < ROW_W'(ROWS)) ? ROW_W'(row_reg + 1'b1) : row_reg;
    assign row_wrap  = wrap_pend ? row_inc : row_reg;
    assign tab_tgt   = (COL_W + 1)'(col_reg) + (COL_W + 1)'(TAB_STOP)
                       - (COL_W + 1)'(phase_reg);
    assign phase_inc = (phase_reg == PH_W'(TAB_STOP - 1)) ? '0 : PH_W'(phase_reg + 1'b1);
    assign put_addr  = ADDR_W'(ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg));
    assign sw_move   = (sw_mode_reg == SW_SCROLL) && (sw_ptr_reg < ADDR_W'(MOVE_N));

    // Memory port selection: sweep writes take priority over the character write
    always_comb begin
        ram_we    = wpend_reg || (state_reg == S_PUT);
        ram_waddr = wpend_reg ? waddr_reg : put_addr;
        ram_wdata = wpend_reg ? (wsrc_reg ? ram_rdata : '0) : {attr_reg, char_reg};
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(in_idx);
        if (state_reg == S_SWEEP && sw_move) begin
            ram_re    = 1'b1;
            ram_raddr = ADDR_W'(sw_ptr_reg + ADDR_W'(COLUMNS));
        end else if (in_take && in_cmd == CMD_READ && idx_ok) begin
            ram_re = 1'b1;
        end
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        sw_mode_next   = sw_mode_reg;
        sw_ptr_next    = sw_ptr_reg;
        wpend_next     = 1'b0;
        waddr_next     = sw_ptr_reg;
        wsrc_next      = sw_move;
        col_next       = col_reg;
        row_next       = row_reg;
        phase_next     = phase_reg;
        attr_next      = cfg_wr_en ? cfg_wr_data : attr_reg;
        char_next      = char_reg;
        rd_hit_next    = rd_hit_reg;
        res_char_next  = res_char_reg;
        res_attr_next  = res_attr_reg;
        res_scr_next   = res_scr_reg;
        out_valid_next = m_axis_tready ? 1'b0 : out_valid_reg;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_take) begin
                    char_next     = in_char;
                    res_char_next = '0;
                    res_attr_next = '0;
                    res_scr_next  = 1'b0;
                    rd_hit_next   = idx_ok;
                    state_next    = S_DONE;
                    unique case (in_cmd)
                        CMD_PUT: begin
                            if (!wrap_pend && is_ctrl) begin
                                // Control codes move the cursor only
                                priority if (in_char == CH_LF) begin
                                    row_next   = row_inc;
                                    col_next   = '0;
                                    phase_next = '0;
                                end else if (in_char == CH_CR) begin
                                    col_next   = '0;
                                    phase_next = '0;
                                end else if (in_char == CH_BS) begin
                                    if (col_reg != '0) begin
                                        col_next   = COL_W'(col_reg - 1'b1);
                                        phase_next = (phase_reg == '0) ?
                                                     PH_W'(TAB_STOP - 1) :
                                                     PH_W'(phase_reg - 1'b1);
                                    end
                                end else begin
                                    if (tab_tgt > (COL_W + 1)'(COLUMNS)) begin
                                        col_next   = COL_W'(COLUMNS);
                                        phase_next = PH_W'(PH_SAT);
                                    end else begin
                                        col_next   = COL_W'(tab_tgt);
                                        phase_next = '0;
                                    end
                                end
                            end else begin
                                // Print: wrap, then scroll if the row overflowed
                                if (wrap_pend) begin
                                    col_next   = '0;
                                    phase_next = '0;
                                end
                                if (row_wrap >= ROW_W'(ROWS)) begin
                                    row_next     = ROW_W'(ROWS - 1);
                                    res_scr_next = 1'b1;
                                    sw_mode_next = SW_SCROLL;
                                    sw_ptr_next  = '0;
                                    state_next   = S_SWEEP;
                                end else begin
                                    row_next   = row_wrap;
                                    state_next = S_PUT;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            col_next     = '0;
                            row_next     = '0;
                            phase_next   = '0;
                            sw_mode_next = SW_CLEAR;
                            sw_ptr_next  = '0;
                            state_next   = S_SWEEP;
                        end
                        CMD_READ: begin
                            state_next = S_RDWAIT;
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                // Queue one cell write per cycle in the write-pending registers, behind its read
                wpend_next = 1'b1;
                if (sw_ptr_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = S_SWEEP_END;
                end else begin
                    sw_ptr_next = ADDR_W'(sw_ptr_reg + 1'b1);
                end
            end
            S_SWEEP_END: begin
                unique case (sw_mode_reg)
                    SW_INIT:   state_next = S_IDLE;
                    SW_CLEAR:  state_next = S_DONE;
                    SW_SCROLL: state_next = S_PUT;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_PUT: begin
                // Character written this cycle; advance the column
                col_next   = COL_W'(col_reg + 1'b1);
                phase_next = phase_inc;
                state_next = S_DONE;
            end
            S_RDWAIT: begin
                if (rd_hit_reg) begin
                    res_char_next = ram_rdata[CHAR_W-1:0];
                    res_attr_next = ram_rdata[CELL_W-1:CHAR_W];
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // Hand the result to the output register once it is free
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {PAD_W'(0), res_scr_reg, res_attr_reg,
                                      res_char_reg, OROW_W'(row_reg), OCOL_W'(col_reg)};
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            sw_mode_reg   <= SW_INIT;
            sw_ptr_reg    <= '0;
            wpend_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            phase_reg     <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sw_mode_reg   <= sw_mode_next;
            sw_ptr_reg    <= sw_ptr_next;
            wpend_reg     <= wpend_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            phase_reg     <= phase_next;
            attr_reg      <= attr_next;
            out_valid_reg <= out_valid_next;
        end
        waddr_reg    <= waddr_next;
        wsrc_reg     <= wsrc_next;
        char_reg     <= char_next;
        rd_hit_reg   <= rd_hit_next;
        res_char_reg <= res_char_next;
        res_attr_reg <= res_attr_next;
        res_scr_reg  <= res_scr_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_screen_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[sim/text_console_writer_top_test.sv]
// Self-checking testbench of the text console writer top level.
// Drives directed and random command words, predicts each untyped result word with a
// cycle-free screen and cursor model; depends on tcw_pkg and the RTL top only.
`timescale 1ns / 1ps

module text_console_writer_top_test;
    import tcw_pkg::*;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = COLUMNS * ROWS;

    // Command code the block leaves without effect
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int PHASES          = 7;
    localparam int WORDS_PER_PHASE = 250;

    typedef struct packed {
        logic [OCOL_W-1:0] col;
        logic [OROW_W-1:0] row;
        logic [CHAR_W-1:0] rchar;
        logic [ATTR_W-1:0] rattr;
        logic              scrolled;
    } result_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        int                repeats;
        bit                typed;
        result_t           want;
    } stim_row_t;

    // Cursor at home, no cell data, no scroll
    localparam result_t HOME_BLANK = '{7'd0, 5'd0, 8'd0, 8'd0, 1'b0};

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [ATTR_W-1:0]   cfg_wr_data   = '0;
    logic                s_axis_tvalid = 1'b0;
    wire                 s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic [CMD_W-1:0]    s_axis_tuser  = '0;
    wire                 m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    wire  [M_DATA_W-1:0] m_axis_tdata;

    bit gaps_on = 1'b1;
    int mismatch_count = 0;

    // Screen and cursor as the block should hold them
    logic [CELL_W-1:0] screen_model [CELLS];
    int                model_col;
    int                model_row;
    logic [ATTR_W-1:0] model_attr;

    result_t expected_results [$];

    // Directed words: typed expectations only where obvious
    stim_row_t directed_table [0:25] = '{
        '{CMD_READ,  8'h00, 11'd0,    1,  1'b1, HOME_BLANK},
        '{CMD_READ,  8'h00, 11'd1999, 1,  1'b1, HOME_BLANK},
        '{CMD_READ,  8'h00, 11'd2000, 1,  1'b1, HOME_BLANK},
        '{CMD_READ,  8'hFF, 11'd2047, 1,  1'b1, HOME_BLANK},
        '{CMD_NONE,  8'hFF, 11'd2047, 1,  1'b1, HOME_BLANK},
        '{CMD_PUT,   8'h41, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_PUT,   8'hFF, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_PUT,   8'h00, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_READ,  8'h00, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_READ,  8'h00, 11'd2,    1,  1'b0, HOME_BLANK},
        '{CMD_PUT,   CH_BS, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_PUT,   CH_CR, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_PUT,   CH_BS, 11'd0,    1,  1'b0, HOME_BLANK},
        // tab stops up to the wrap-pending column
        '{CMD_PUT,   CH_TAB, 11'd0,   10, 1'b0, HOME_BLANK},
        // newline while wrap pending is printed
        '{CMD_PUT,   CH_LF, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_PUT,   CH_CR, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_PUT,   CH_TAB, 11'd0,   9,  1'b0, HOME_BLANK},
        '{CMD_PUT,   8'h78, 11'd0,    8,  1'b0, HOME_BLANK},
        '{CMD_PUT,   CH_BS, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_READ,  8'h00, 11'd160,  1,  1'b0, HOME_BLANK},
        // newlines past the bottom row leave a scroll pending
        '{CMD_PUT,   CH_LF, 11'd0,    24, 1'b0, HOME_BLANK},
        '{CMD_PUT,   8'h5A, 11'd0,    1,  1'b0, HOME_BLANK},
        '{CMD_READ,  8'h00, 11'd1920, 1,  1'b0, HOME_BLANK},
        '{CMD_READ,  8'h00, 11'd80,   1,  1'b0, HOME_BLANK},
        '{CMD_CLEAR, 8'hFF, 11'd2047, 1,  1'b1, HOME_BLANK},
        '{CMD_READ,  8'h00, 11'd1920, 1,  1'b1, HOME_BLANK}
    };

    text_console_writer_top #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    initial begin
        #200_000_000;
        $display("simulation failed");
        $finish;
    end

    // Advance the screen model by one command word and return its result word
    function automatic result_t console_step(input logic [CMD_W-1:0] cmd,
                                             input logic [CHAR_W-1:0] ch,
                                             input logic [IDX_W-1:0] idx);
        result_t r;
        bit      printing;
        int      stop;
        r = '0;
        printing = 1'b0;
        case (cmd)
            CMD_PUT: begin
                if (model_col >= COLUMNS) begin
                    // wrap first; control codes print as plain characters here
                    if (model_row < ROWS) model_row++;
                    model_col = 0;
                    printing = 1'b1;
                end else begin
                    case (ch)
                        CH_LF: begin
                            if (model_row < ROWS) model_row++;
                            model_col = 0;
                        end
                        CH_CR: model_col = 0;
                        CH_BS: if (model_col > 0) model_col--;
                        CH_TAB: begin
                            stop = (model_col / TAB_STOP + 1) * TAB_STOP;
                            model_col = (stop > COLUMNS) ? COLUMNS : stop;
                        end
                        default: printing = 1'b1;
                    endcase
                end
                if (printing) begin
                    if (model_row >= ROWS) begin
                        // move rows up and blank the bottom one
                        for (int i = 0; i < CELLS - COLUMNS; i++)
                            screen_model[i] = screen_model[i + COLUMNS];
                        for (int i = CELLS - COLUMNS; i < CELLS; i++)
                            screen_model[i] = '0;
                        model_row = ROWS - 1;
                        r.scrolled = 1'b1;
                    end
                    screen_model[model_row * COLUMNS + model_col] = {model_attr, ch};
                    model_col++;
                end
            end
            CMD_CLEAR: begin
                foreach (screen_model[i]) screen_model[i] = '0;
                model_col = 0;
                model_row = 0;
            end
            CMD_READ: begin
                if (idx < CELLS) begin
                    r.rchar = screen_model[idx][CHAR_W-1:0];
                    r.rattr = screen_model[idx][CELL_W-1:CHAR_W];
                end
            end
            default: ;
        endcase
        r.col = model_col[OCOL_W-1:0];
        r.row = model_row[OROW_W-1:0];
        return r;
    endfunction

    // Offer one command word, hold it until taken, then queue its result
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                             input logic [IDX_W-1:0] idx, input bit typed,
                             input result_t want);
        result_t predicted;
        while (gaps_on && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_DATA_W - IDX_W - CHAR_W){1'b0}}, idx, ch};
        s_axis_tuser  <= cmd;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = console_step(cmd, ch, idx);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        model_attr = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Throttle the result side
    always @(posedge aclk) begin
        m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 33);
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.col      = m_axis_tdata[6:0];
            got.row      = m_axis_tdata[11:7];
            got.rchar    = m_axis_tdata[19:12];
            got.rattr    = m_axis_tdata[27:20];
            got.scrolled = m_axis_tdata[28];
            if (expected_results.size() == 0) begin
                $error("result word %h with none expected", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.col !== want.col) begin
                    $error("cursor_col: expected %0d, got %0d", want.col, got.col);
                    mismatch_count++;
                end
                if (got.row !== want.row) begin
                    $error("cursor_row: expected %0d, got %0d", want.row, got.row);
                    mismatch_count++;
                end
                if (got.rchar !== want.rchar) begin
                    $error("read_char: expected %0d, got %0d", want.rchar, got.rchar);
                    mismatch_count++;
                end
                if (got.rattr !== want.rattr) begin
                    $error("read_attr: expected %0d, got %0d", want.rattr, got.rattr);
                    mismatch_count++;
                end
                if (got.scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0d, got %0d", want.scrolled, got.scrolled);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int                phase;
        int                n;
        int                pick;
        int                near_row;
        logic [CMD_W-1:0]  cmd;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;

        foreach (screen_model[i]) screen_model[i] = '0;
        model_col  = 0;
        model_row  = 0;
        model_attr = ATTR_RESET;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with the reset attribute
        foreach (directed_table[r]) begin
            for (n = 0; n < directed_table[r].repeats; n++)
                send_word(directed_table[r].cmd, directed_table[r].ch, directed_table[r].idx,
                          directed_table[r].typed, directed_table[r].want);
        end

        // Random phases, each under its own attribute, drained before the write
        for (phase = 0; phase < PHASES; phase++) begin
            s_axis_tvalid <= 1'b0;
            while (expected_results.size() != 0) @(posedge aclk);
            case (phase)
                0: write_attribute(8'h00);
                1: write_attribute(8'hFF);
                default: write_attribute(ATTR_W'($urandom_range(0, 255)));
            endcase
            gaps_on <= (phase != 1);
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                cmd  = CMD_PUT;
                ch   = CHAR_W'($urandom_range(32, 126));
                idx  = IDX_W'($urandom_range(0, 2047));
                if (pick < 50) begin
                    // printable text, already set up
                end else if (pick < 56) begin
                    ch = CH_LF;
                end else if (pick < 59) begin
                    ch = CH_CR;
                end else if (pick < 63) begin
                    ch = CH_BS;
                end else if (pick < 68) begin
                    ch = CH_TAB;
                end else if (pick < 73) begin
                    ch = CHAR_W'($urandom_range(0, 255));
                end else if (pick < 90) begin
                    cmd = CMD_READ;
                    ch  = CHAR_W'($urandom_range(0, 255));
                    // half the time around the cursor row, where text lands
                    if ($urandom_range(0, 1) == 0) begin
                        near_row = (model_row >= ROWS) ? ROWS - 1 : model_row;
                        idx = IDX_W'(near_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
                    end
                end else if (pick < 91) begin
                    cmd = CMD_CLEAR;
                    ch  = CHAR_W'($urandom_range(0, 255));
                end else if (pick < 93) begin
                    cmd = CMD_NONE;
                    ch  = CHAR_W'($urandom_range(0, 255));
                end
                send_word(cmd, ch, idx, 1'b0, HOME_BLANK);
            end
        end

        // Drain, then allow stray words to show up
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/text_console_writer_top.sv
sim/text_console_writer_top_test.sv
